// File: sv/prq_pkg.sv
// ----------------------------------------------------------------------------
// Priority run queue package
// Field widths, request codes and status codes shared by the run queue files.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CPU_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Width of one occupancy map word; the scan resolves one word per cycle.
  localparam int unsigned MAP_WORD_W = 64;

  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EXTRACT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_ANY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

// File: sv/prq_ram.sv
// ----------------------------------------------------------------------------
// Run queue RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/prq_level_map.sv
// ----------------------------------------------------------------------------
// Run queue level map
// Occupancy bitmap over the priority levels with a one-word-per-cycle
// downward scan for the highest occupied level at or below a cursor.
// ----------------------------------------------------------------------------
module prq_level_map #(
  parameter int unsigned NUM_LEVELS = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    set_i,
  input  logic                    clr_i,
  input  logic [$clog2(NUM_LEVELS)-1:0] level_i,
  output logic                    occupied_o,
  input  logic [$clog2(((NUM_LEVELS + prq_pkg::MAP_WORD_W - 1) / prq_pkg::MAP_WORD_W)
                       * prq_pkg::MAP_WORD_W)-1:0] cursor_i,
  output logic                    hit_o,
  output logic [$clog2(((NUM_LEVELS + prq_pkg::MAP_WORD_W - 1) / prq_pkg::MAP_WORD_W)
                       * prq_pkg::MAP_WORD_W)-1:0] hit_level_o,
  output logic [$clog2(((NUM_LEVELS + prq_pkg::MAP_WORD_W - 1) / prq_pkg::MAP_WORD_W)
                       * prq_pkg::MAP_WORD_W)-1:0] word_base_o
);

  localparam int unsigned WW = prq_pkg::MAP_WORD_W;
  localparam int unsigned MW = (NUM_LEVELS + WW - 1) / WW;
  localparam int unsigned CW = $clog2(MW * WW);
  localparam int unsigned BW = $clog2(WW);

  logic [MW*WW-1:0] map_q;
  logic [MW*WW-1:0] map_d;
  logic [CW-1:0]    base;
  logic [WW-1:0]    word;
  logic [WW-1:0]    masked;
  logic [BW-1:0]    pos;
  logic             hit;

  always_comb begin
    map_d = map_q;
    if (set_i) begin
      map_d[level_i] = 1'b1;
    end
    if (clr_i) begin
      map_d[level_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
  end

  assign occupied_o = map_q[level_i];

  assign base   = cursor_i & ~CW'(WW - 1);
  assign word   = map_q[base +: WW];
  assign masked = word & ({WW{1'b1}} >> (BW'(WW - 1) - cursor_i[BW-1:0]));

  // Highest set bit of the word wins.
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < WW; i++) begin
      if (masked[i]) begin
        hit = 1'b1;
        pos = BW'(i);
      end
    end
  end

  assign hit_o       = hit;
  assign hit_level_o = base | CW'(pos);
  assign word_base_o = base;

  property p_set_visible;
    @(posedge clk_i) disable iff (!rst_ni) (set_i && !clr_i) |=> map_q[$past(level_i)];
  endproperty
  a_set_visible: assert property (p_set_visible) else $error("level bit not set");

  property p_no_high_bits;
    @(posedge clk_i) disable iff (!rst_ni) hit_o |-> (hit_level_o <= cursor_i);
  endproperty
  a_no_high_bits: assert property (p_no_high_bits) else $error("scan hit above cursor");

  property p_hit_is_set;
    @(posedge clk_i) disable iff (!rst_ni) hit_o |-> map_q[hit_level_o];
  endproperty
  a_hit_is_set: assert property (p_hit_is_set) else $error("scan hit on clear bit");

endmodule

// File: sv/priority_run_queue_with_affinity_core.sv
// Steps: insert reads the level tail, then writes the links; remove reads the slot's links
// and level, then unlinks it; peek scans 64-level map words downward and reads the level head,
// and with affinity walks the slots on the level lists; extract then unlinks the chosen slot.
// One request at a time; the next is taken as soon as the previous result is registered.
// Reset clears the level map, the queued flags and control; list RAMs need no clearing.
// ----------------------------------------------------------------------------
// Priority run queue core
// Per-level FIFO lists of task slots kept in RAMs, with an occupancy map and
// an affinity-aware search for the next slot to run on a CPU.
// ----------------------------------------------------------------------------
module priority_run_queue_with_affinity_core #(
  parameter int unsigned NUM_LEVELS = 256,
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned NUM_CPUS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [prq_pkg::SLOT_W-1:0]    task_slot_i,
  input  logic [prq_pkg::LEVEL_W-1:0]   task_level_i,
  input  logic [prq_pkg::MASK_W-1:0]    task_affinity_i,
  input  logic [prq_pkg::CPU_W-1:0]     cpu_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prq_pkg::STATUS_W-1:0]  status_o,
  output logic [prq_pkg::SLOT_W-1:0]    chosen_slot_o,
  output logic [prq_pkg::LEVEL_W-1:0]   chosen_level_o
);

  localparam int unsigned SW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SAW = $clog2(NUM_SLOTS);
  localparam int unsigned LW  = $clog2(NUM_LEVELS);
  localparam int unsigned WW  = prq_pkg::MAP_WORD_W;
  localparam int unsigned CW  = $clog2(((NUM_LEVELS + WW - 1) / WW) * WW);
  localparam logic [SW-1:0] NIL = SW'(NUM_SLOTS);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_INS_RD   = 11'b00000000010,
    S_INS_WR   = 11'b00000000100,
    S_INS_LINK = 11'b00000001000,
    S_RM_RD    = 11'b00000010000,
    S_RM_WR    = 11'b00000100000,
    S_SCAN     = 11'b00001000000,
    S_HEAD_RD  = 11'b00010000000,
    S_HEAD_USE = 11'b00100000000,
    S_WALK_RD  = 11'b01000000000,
    S_WALK_CHK = 11'b10000000000
  } state_e;

  localparam state_e S_FIN_CODE = S_IDLE;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  logic [prq_pkg::REQ_W-1:0]    req_q, req_d;
  logic [SW-1:0]                slot_q, slot_d;
  logic [LW-1:0]                lvl_q, lvl_d;
  logic [prq_pkg::MASK_W-1:0]   aff_q, aff_d;
  logic [prq_pkg::CPU_W-1:0]    cpu_q, cpu_d;
  logic [CW-1:0]                cur_q, cur_d;
  logic [prq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [SW-1:0]                res_slot_q, res_slot_d;
  logic [LW-1:0]                res_lvl_q, res_lvl_d;
  logic [NUM_SLOTS-1:0]         queued_q, queued_d;

  logic                         out_valid_q, out_valid_d;
  logic [prq_pkg::STATUS_W-1:0] out_status_q;
  logic [prq_pkg::SLOT_W-1:0]   out_slot_q;
  logic [prq_pkg::LEVEL_W-1:0]  out_lvl_q;

  // RAM ports
  logic           nx_we, pv_we, hd_we, tl_we, sl_we;
  logic [SAW-1:0] nx_wa, pv_wa;
  logic [SW-1:0]  nx_wd, pv_wd, hd_wd, tl_wd;
  logic [LW-1:0]  hd_wa, tl_wa;
  logic [SW-1:0]  nx_rd, pv_rd, hd_rd, tl_rd;
  logic [LW-1:0]  lv_rd;
  logic [prq_pkg::MASK_W-1:0] mk_rd;

  // Level map ports
  logic          map_set, map_clr, map_occ, map_hit;
  logic [LW-1:0] map_lvl;
  logic [CW-1:0] map_hit_lvl, map_base;

  logic          accept, fin_go;
  logic          in_slot_ok, in_cpu_ok;
  logic [LW-1:0] in_lvl;
  logic          mask_hit;

  prq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(SAW'(slot_q)), .rdata_o(nx_rd)
  );
  prq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .raddr_i(SAW'(slot_q)), .rdata_o(pv_rd)
  );
  prq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LW)) u_slot_level (
    .clk_i, .we_i(sl_we), .waddr_i(SAW'(slot_q)), .wdata_i(lvl_q),
    .raddr_i(SAW'(slot_q)), .rdata_o(lv_rd)
  );
  prq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(prq_pkg::MASK_W)) u_slot_mask (
    .clk_i, .we_i(sl_we), .waddr_i(SAW'(slot_q)), .wdata_i(aff_q),
    .raddr_i(SAW'(slot_q)), .rdata_o(mk_rd)
  );
  prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(SW)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd),
    .raddr_i(lvl_q), .rdata_o(hd_rd)
  );
  prq_ram #(.DEPTH(NUM_LEVELS), .WIDTH(SW)) u_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd),
    .raddr_i(lvl_q), .rdata_o(tl_rd)
  );

  prq_level_map #(.NUM_LEVELS(NUM_LEVELS)) u_map (
    .clk_i, .rst_ni, .set_i(map_set), .clr_i(map_clr), .level_i(map_lvl),
    .occupied_o(map_occ), .cursor_i(cur_q), .hit_o(map_hit),
    .hit_level_o(map_hit_lvl), .word_base_o(map_base)
  );

  assign in_ready_o = (state_q == S_IDLE) && !fin_q;
  assign accept     = in_valid_i && in_ready_o;
  assign fin_go     = fin_q && (!out_valid_q || out_ready_i);

  assign in_slot_ok = int'(task_slot_i) < NUM_SLOTS;
  assign in_cpu_ok  = int'(cpu_index_i) < NUM_CPUS;
  assign in_lvl     = (int'(task_level_i) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                         : LW'(task_level_i);
  assign mask_hit   = mk_rd[cpu_q];

  always_comb begin
    state_d      = state_q;
    fin_d        = fin_q;
    req_d        = req_q;
    slot_d       = slot_q;
    lvl_d        = lvl_q;
    aff_d        = aff_q;
    cpu_d        = cpu_q;
    cur_d        = cur_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_lvl_d    = res_lvl_q;
    queued_d     = queued_q;
    nx_we = 1'b0; nx_wa = SAW'(slot_q); nx_wd = NIL;
    pv_we = 1'b0; pv_wa = SAW'(slot_q); pv_wd = NIL;
    hd_we = 1'b0; hd_wa = lvl_q;        hd_wd = slot_q;
    tl_we = 1'b0; tl_wa = lvl_q;        tl_wd = slot_q;
    sl_we = 1'b0;
    map_set = 1'b0;
    map_clr = 1'b0;
    map_lvl = lvl_q;

    if (fin_go) begin
      fin_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d        = req_type_i;
          slot_d       = SW'(task_slot_i);
          lvl_d        = in_lvl;
          aff_d        = task_affinity_i;
          cpu_d        = cpu_index_i;
          res_status_d = prq_pkg::ST_NONE;
          res_slot_d   = '0;
          res_lvl_d    = '0;
          cur_d        = CW'(NUM_LEVELS - 1);
          unique case (req_type_i)
            prq_pkg::REQ_INSERT: begin
              if (!in_slot_ok || queued_q[SAW'(task_slot_i)]) begin
                res_status_d = prq_pkg::ST_BAD;
                fin_d        = 1'b1;
              end else begin
                state_d = S_INS_RD;
              end
            end
            prq_pkg::REQ_REMOVE: begin
              if (!in_slot_ok || !queued_q[SAW'(task_slot_i)]) begin
                res_status_d = prq_pkg::ST_BAD;
                fin_d        = 1'b1;
              end else begin
                res_status_d = prq_pkg::ST_OK;
                state_d      = S_RM_RD;
              end
            end
            prq_pkg::REQ_PEEK, prq_pkg::REQ_EXTRACT: begin
              if (in_cpu_ok) begin
                state_d = S_SCAN;
              end else begin
                fin_d = 1'b1;
              end
            end
            prq_pkg::REQ_PEEK_ANY: begin
              state_d = S_SCAN;
            end
            default: begin
              fin_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        // Tail of the level is being read.
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        sl_we = 1'b1;
        tl_we = 1'b1;
        pv_we = 1'b1;
        queued_d[SAW'(slot_q)] = 1'b1;
        if (map_occ) begin
          nx_we = 1'b1;
          nx_wa = SAW'(tl_rd);
          nx_wd = slot_q;
          pv_wd = tl_rd;
        end else begin
          hd_we   = 1'b1;
          map_set = 1'b1;
        end
        state_d = S_INS_LINK;
      end
      S_INS_LINK: begin
        nx_we        = 1'b1;
        res_status_d = prq_pkg::ST_OK;
        fin_d        = 1'b1;
        state_d      = S_IDLE;
      end
      S_RM_RD: begin
        // Links and level of the slot are being read.
        state_d = S_RM_WR;
      end
      S_RM_WR: begin
        hd_wa   = lv_rd;
        tl_wa   = lv_rd;
        map_lvl = lv_rd;
        if (pv_rd == NIL) begin
          hd_we = 1'b1;
          hd_wd = nx_rd;
        end else begin
          nx_we = 1'b1;
          nx_wa = SAW'(pv_rd);
          nx_wd = nx_rd;
        end
        if (nx_rd == NIL) begin
          tl_we = 1'b1;
          tl_wd = pv_rd;
        end else begin
          pv_we = 1'b1;
          pv_wa = SAW'(nx_rd);
          pv_wd = pv_rd;
        end
        map_clr = (pv_rd == NIL) && (nx_rd == NIL);
        queued_d[SAW'(slot_q)] = 1'b0;
        fin_d   = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (map_hit) begin
          lvl_d   = LW'(map_hit_lvl);
          state_d = S_HEAD_RD;
        end else if (map_base == '0) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d = map_base - CW'(1);
        end
      end
      S_HEAD_RD: begin
        state_d = S_HEAD_USE;
      end
      S_HEAD_USE: begin
        if (req_q == prq_pkg::REQ_PEEK_ANY) begin
          res_status_d = prq_pkg::ST_OK;
          res_slot_d   = hd_rd;
          res_lvl_d    = lvl_q;
          fin_d        = 1'b1;
          state_d      = S_IDLE;
        end else begin
          slot_d  = hd_rd;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (mask_hit) begin
          res_status_d = prq_pkg::ST_OK;
          res_slot_d   = slot_q;
          res_lvl_d    = lvl_q;
          if (req_q == prq_pkg::REQ_EXTRACT) begin
            state_d = S_RM_RD;
          end else begin
            fin_d   = 1'b1;
            state_d = S_IDLE;
          end
        end else if (nx_rd != NIL) begin
          slot_d  = nx_rd;
          state_d = S_WALK_RD;
        end else if (lvl_q == '0) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cur_d   = CW'(lvl_q) - CW'(1);
          state_d = S_SCAN;
        end
      end
      default: begin
        state_d = S_FIN_CODE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      queued_q    <= queued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    slot_q       <= slot_d;
    lvl_q        <= lvl_d;
    aff_q        <= aff_d;
    cpu_q        <= cpu_d;
    cur_q        <= cur_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_lvl_q    <= res_lvl_d;
    if (fin_go) begin
      out_status_q <= res_status_q;
      out_slot_q   <= prq_pkg::SLOT_W'(res_slot_q);
      out_lvl_q    <= prq_pkg::LEVEL_W'(res_lvl_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chosen_slot_o  = out_slot_q;
  assign chosen_level_o = out_lvl_q;

  property p_state_onehot;
    @(posedge clk_i) disable iff (!rst_ni) $onehot(state_q);
  endproperty
  a_state_onehot: assert property (p_state_onehot) else $error("state not one-hot");

  property p_fin_delivers;
    @(posedge clk_i) disable iff (!rst_ni) fin_go |=> out_valid_q && !fin_q;
  endproperty
  a_fin_delivers: assert property (p_fin_delivers) else $error("result not registered");

  property p_status_legal;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (status_o == prq_pkg::ST_OK || status_o == prq_pkg::ST_NONE ||
                       status_o == prq_pkg::ST_BAD);
  endproperty
  a_status_legal: assert property (p_status_legal) else $error("illegal status");

  property p_no_accept_while_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> !in_ready_o;
  endproperty
  a_no_accept_while_busy: assert property (p_no_accept_while_busy)
    else $error("ready while busy");

endmodule

// File: bench/prq_checker.sv
// ----------------------------------------------------------------------------
// Run queue result checker
// Watches both channels of the run queue core, keeps its own copy of the
// per-level lists, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module prq_checker #(
  parameter int unsigned NUM_LEVELS = 256,
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned NUM_CPUS   = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [prq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [prq_pkg::SLOT_W-1:0]   task_slot_i,
  input  logic [prq_pkg::LEVEL_W-1:0]  task_level_i,
  input  logic [prq_pkg::MASK_W-1:0]   task_affinity_i,
  input  logic [prq_pkg::CPU_W-1:0]    cpu_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [prq_pkg::STATUS_W-1:0] status_i,
  input  logic [prq_pkg::SLOT_W-1:0]   chosen_slot_i,
  input  logic [prq_pkg::LEVEL_W-1:0]  chosen_level_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NIL = NUM_SLOTS;

  typedef struct packed {
    logic [prq_pkg::STATUS_W-1:0] status;
    logic [prq_pkg::SLOT_W-1:0]   slot;
    logic [prq_pkg::LEVEL_W-1:0]  level;
  } sched_result_t;

  sched_result_t result_q[$];

  logic [NUM_LEVELS-1:0]      occupied;
  int unsigned                head_of[NUM_LEVELS];
  int unsigned                tail_of[NUM_LEVELS];
  int unsigned                next_of[NUM_SLOTS];
  int unsigned                prev_of[NUM_SLOTS];
  int unsigned                level_of[NUM_SLOTS];
  logic [prq_pkg::MASK_W-1:0] mask_of[NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       queued;

  function automatic void unlink(int unsigned s);
    int unsigned lv, p, n;
    lv = level_of[s];
    p  = prev_of[s];
    n  = next_of[s];
    if (p == NIL) head_of[lv] = n;
    else next_of[p] = n;
    if (n == NIL) tail_of[lv] = p;
    else prev_of[n] = p;
    queued[s] = 1'b0;
    if (head_of[lv] == NIL) occupied[lv] = 1'b0;
  endfunction

  // Highest occupied level first, then the oldest slot the cpu may run, or its head for any cpu.
  function automatic int unsigned pick_slot(int unsigned cpu, bit any_cpu);
    int unsigned s;
    for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
      if (occupied[lv]) begin
        s = head_of[lv];
        if (any_cpu) return s;
        while (s != NIL) begin
          if (mask_of[s][cpu]) return s;
          s = next_of[s];
        end
      end
    end
    return NIL;
  endfunction

  function automatic sched_result_t schedule(logic [prq_pkg::REQ_W-1:0] req,
                                             int unsigned slot, int unsigned lv,
                                             logic [prq_pkg::MASK_W-1:0] aff,
                                             int unsigned cpu);
    sched_result_t r;
    int unsigned   s;
    r = '{status: prq_pkg::ST_NONE, slot: '0, level: '0};
    if (req == prq_pkg::REQ_INSERT) begin
      if (slot >= NUM_SLOTS || queued[slot]) begin
        r.status = prq_pkg::ST_BAD;
      end else begin
        if (lv >= NUM_LEVELS) lv = NUM_LEVELS - 1;
        level_of[slot] = lv;
        mask_of[slot]  = aff;
        next_of[slot]  = NIL;
        if (occupied[lv]) begin
          prev_of[slot]        = tail_of[lv];
          next_of[tail_of[lv]] = slot;
        end else begin
          prev_of[slot] = NIL;
          head_of[lv]   = slot;
          occupied[lv]  = 1'b1;
        end
        tail_of[lv]  = slot;
        queued[slot] = 1'b1;
        r.status     = prq_pkg::ST_OK;
      end
    end else if (req == prq_pkg::REQ_REMOVE) begin
      if (slot >= NUM_SLOTS || !queued[slot]) begin
        r.status = prq_pkg::ST_BAD;
      end else begin
        unlink(slot);
        r.status = prq_pkg::ST_OK;
      end
    end else if (req == prq_pkg::REQ_PEEK || req == prq_pkg::REQ_EXTRACT ||
                 req == prq_pkg::REQ_PEEK_ANY) begin
      s = NIL;
      if (req == prq_pkg::REQ_PEEK_ANY) s = pick_slot(0, 1'b1);
      else if (cpu < NUM_CPUS) s = pick_slot(cpu, 1'b0);
      if (s != NIL) begin
        r.status = prq_pkg::ST_OK;
        r.slot   = s[prq_pkg::SLOT_W-1:0];
        r.level  = level_of[s][prq_pkg::LEVEL_W-1:0];
        if (req == prq_pkg::REQ_EXTRACT) unlink(s);
      end
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    occupied     = '0;
    queued       = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want, got;
    if (!rst_ni) begin
      occupied = '0;
      queued   = '0;
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{status: status_i, slot: chosen_slot_i, level: chosen_level_i};
        if (result_q.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d slot %0d level %0d",
                   $time, got.status, got.slot, got.level);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected status %0d slot %0d level %0d, got %0d %0d %0d",
                     $time, want.status, want.slot, want.level,
                     got.status, got.slot, got.level);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        result_q.push_back(schedule(req_type_i, 32'(task_slot_i), 32'(task_level_i),
                                    task_affinity_i, 32'(cpu_index_i)));
    end
    pending_o = result_q.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Run queue core testbench
// Drives directed and random insert, remove, peek and extract beats with
// random idling on both channels; a checker beside the core judges results.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1530;
  localparam int CALM_ITEMS   = 200;
  localparam int STALL_LIMIT  = 5000;

  logic                         clk, rst_n;
  logic                         in_valid, in_ready, out_valid, out_ready;
  logic [prq_pkg::REQ_W-1:0]    req_type;
  logic [prq_pkg::SLOT_W-1:0]   task_slot;
  logic [prq_pkg::LEVEL_W-1:0]  task_level;
  logic [prq_pkg::MASK_W-1:0]   task_affinity;
  logic [prq_pkg::CPU_W-1:0]    cpu_index;
  logic [prq_pkg::STATUS_W-1:0] status;
  logic [prq_pkg::SLOT_W-1:0]   chosen_slot;
  logic [prq_pkg::LEVEL_W-1:0]  chosen_level;
  int                           fail_count, pending;
  bit                           calm;
  int                           stall_cycles;

  priority_run_queue_with_affinity_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .task_slot_i(task_slot), .task_level_i(task_level),
    .task_affinity_i(task_affinity), .cpu_index_i(cpu_index),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .chosen_slot_o(chosen_slot), .chosen_level_o(chosen_level)
  );

  prq_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .task_slot_i(task_slot), .task_level_i(task_level),
    .task_affinity_i(task_affinity), .cpu_index_i(cpu_index),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .chosen_slot_i(chosen_slot), .chosen_level_i(chosen_level),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one request beat; an idle burst may come first unless the run is calm.
  task automatic send(logic [prq_pkg::REQ_W-1:0] req, logic [prq_pkg::SLOT_W-1:0] slot,
                      logic [prq_pkg::LEVEL_W-1:0] lv, logic [prq_pkg::MASK_W-1:0] aff,
                      logic [prq_pkg::CPU_W-1:0] cpu);
    @(negedge clk);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(10, 1) - 1) @(negedge clk);
      @(negedge clk);
    end
    req_type      = req;
    task_slot     = slot;
    task_level    = lv;
    task_affinity = aff;
    cpu_index     = cpu;
    in_valid      = 1'b1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Small pools of slots and levels keep lists long and inserts colliding.
  task automatic send_random();
    int unsigned                 pick;
    logic [prq_pkg::SLOT_W-1:0]  slot;
    logic [prq_pkg::LEVEL_W-1:0] lv;
    logic [prq_pkg::REQ_W-1:0]   req;
    pick = $urandom_range(99);
    slot = ($urandom_range(9) < 7) ? prq_pkg::SLOT_W'($urandom_range(15))
                                   : prq_pkg::SLOT_W'($urandom);
    lv   = ($urandom_range(9) < 6) ? prq_pkg::LEVEL_W'($urandom_range(3))
                                   : prq_pkg::LEVEL_W'($urandom);
    if (pick < 38)      req = prq_pkg::REQ_INSERT;
    else if (pick < 52) req = prq_pkg::REQ_REMOVE;
    else if (pick < 67) req = prq_pkg::REQ_PEEK;
    else if (pick < 90) req = prq_pkg::REQ_EXTRACT;
    else if (pick < 97) req = prq_pkg::REQ_PEEK_ANY;
    else                req = prq_pkg::REQ_W'($urandom_range(7, 5));
    send(req, slot, lv, prq_pkg::MASK_W'($urandom), prq_pkg::CPU_W'($urandom));
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'($urandom_range(1));
        repeat ($urandom_range(10, 1) - 1) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("priority_run_queue_with_affinity_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    in_valid      = 1'b0;
    req_type      = prq_pkg::REQ_INSERT;
    task_slot     = '0;
    task_level    = '0;
    task_affinity = '0;
    cpu_index     = '0;
    calm          = 1'b0;
    rst_n         = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty queue, extremes, bad requests, undefined codes.
    send(prq_pkg::REQ_PEEK, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_PEEK_ANY, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_EXTRACT, 6'd0, 8'd0, 8'h00, 3'd7);
    send(prq_pkg::REQ_REMOVE, 6'd5, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_INSERT, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_INSERT, 6'd63, 8'd255, 8'hff, 3'd0);
    send(prq_pkg::REQ_INSERT, 6'd63, 8'd3, 8'h01, 3'd0);
    send(prq_pkg::REQ_INSERT, 6'd1, 8'd255, 8'h80, 3'd0);
    send(prq_pkg::REQ_INSERT, 6'd2, 8'd128, 8'h01, 3'd0);
    send(prq_pkg::REQ_PEEK, 6'd0, 8'd0, 8'h00, 3'd7);
    send(prq_pkg::REQ_PEEK, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_PEEK_ANY, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_EXTRACT, 6'd0, 8'd0, 8'h00, 3'd7);
    send(prq_pkg::REQ_EXTRACT, 6'd0, 8'd0, 8'h00, 3'd7);
    send(prq_pkg::REQ_EXTRACT, 6'd0, 8'd0, 8'h00, 3'd3);
    send(prq_pkg::REQ_REMOVE, 6'd63, 8'd0, 8'h00, 3'd0);
    send(3'd5, 6'd1, 8'd1, 8'h01, 3'd1);
    send(3'd6, 6'd2, 8'd2, 8'h02, 3'd2);
    send(3'd7, 6'd63, 8'd255, 8'hff, 3'd7);
    send(prq_pkg::REQ_PEEK, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_PEEK_ANY, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_REMOVE, 6'd0, 8'd0, 8'h00, 3'd0);
    send(prq_pkg::REQ_EXTRACT, 6'd0, 8'd0, 8'h00, 3'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random();
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_run_queue_with_affinity_core: match");
    end else begin
      $display("priority_run_queue_with_affinity_core: mismatch");
    end
    $finish;
  end

endmodule
